>>> hdl/riot_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riot_pkg
// Shared types and constants of the RAM, I/O and timer block.
// ----------------------------------------------------------------------------
package riot_pkg;

	localparam int RAM_DEPTH = 128;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int ADDR_W    = 10;
	localparam int IO_BIT    = 9;
	localparam int TIMER_W   = 20;

	// Bus command codes
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} riot_cmd_e;

	// Register select, low three address bits on an I/O read
	typedef enum logic [2:0] {
		REG_PORTA     = 3'd0,
		REG_DDRA      = 3'd1,
		REG_PORTB     = 3'd2,
		REG_DDRB      = 3'd3,
		REG_TIMER     = 3'd4,
		REG_FLAG      = 3'd5,
		REG_TIMER_ALT = 3'd6,
		REG_FLAG_ALT  = 3'd7
	} riot_reg_e;

	// Port A write select, low two address bits
	localparam logic [1:0] PA_SEL_LATCH = 2'd0;
	localparam logic [1:0] PA_SEL_DDR   = 2'd1;

	// Configuration register indexes
	localparam logic CFG_LEFT_PRESENT  = 1'b0;
	localparam logic CFG_RIGHT_PRESENT = 1'b1;

	localparam logic [3:0] PRESCALE_SHIFT [4] = '{4'd0, 4'd3, 4'd6, 4'd10};
	localparam logic [3:0] SHIFT_RESET = 4'd10;
	localparam logic signed [TIMER_W-1:0] TIMER_RESET = 20'sd261120;
	localparam logic signed [TIMER_W-1:0] TIMER_FLOOR = -20'sd257;
	localparam logic signed [TIMER_W-1:0] TIMER_LOW_READ = -20'sd256;
	localparam logic signed [TIMER_W-1:0] TIMER_MINUS_ONE = -20'sd1;

	localparam logic [7:0] PORTB_COLOUR = 8'h08;
	localparam logic [7:0] FLAG_SET = 8'h80;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] address;
		logic [7:0]        write_data;
		logic [3:0]        left_stick;
		logic [3:0]        right_stick;
		logic              reset_switch;
		logic              select_switch;
		logic              left_difficulty;
		logic              right_difficulty;
	} riot_req_t;

	typedef struct packed {
		logic [7:0] read_data;
	} riot_rsp_t;

	// Item in the work stage and its commit strobe
	typedef struct packed {
		logic      fire;
		riot_req_t item;
	} riot_op_t;

endpackage
`default_nettype wire

>>> hdl/riot_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riot_req_if
// Request channel: bus read, bus write or clock tick with input levels.
// ----------------------------------------------------------------------------
interface riot_req_if;
	import riot_pkg::*;

	logic      valid;
	logic      ready;
	riot_req_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);

endinterface
`default_nettype wire

>>> hdl/riot_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riot_rsp_if
// Response channel: one byte per request.
// ----------------------------------------------------------------------------
interface riot_rsp_if;
	import riot_pkg::*;

	logic      valid;
	logic      ready;
	riot_rsp_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);

endinterface
`default_nettype wire

>>> hdl/ram_io_timer_6532.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ram_io_timer_6532
// RAM, I/O and interval timer: 128-byte scratch RAM, joystick and switch
// ports and a prescaled countdown timer behind one request channel.
//
//   channel  dir  payload                                  handshake
//   req      in   cmd, address, write_data, stick/switches valid/ready
//   rsp      out  read_data                                valid/ready
//   cfg      in   cfg_index, cfg_data                      cfg_we
//
// One item per clock while the output is not stalled. A request is registered in
// the work stage (where the RAM read data arrives) and its byte then lands in the
// output register, which drives the response.
// The RAM comes up zero at power-up and keeps its contents through reset;
// reset clears the ports and loads the timer with its reset count.
// A stalled output holds the work stage, and req.ready drops only then.
// ----------------------------------------------------------------------------
module ram_io_timer_6532 (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_index,
	input  wire logic  cfg_data,
	riot_req_if.sink   req,
	riot_rsp_if.source rsp
);
	import riot_pkg::*;

	logic              left_present_q;
	logic              right_present_q;

	logic              s1_valid_q;
	riot_req_t         item_s1;
	logic              fwd_s1;
	logic [7:0]        fwd_data_s1;

	logic              rsp_valid_q;
	logic [7:0]        rsp_data_q;

	logic              accept;
	logic              out_free;
	logic              s1_fire;
	logic              ram_wr;
	logic [RAM_AW-1:0] ram_waddr;
	logic [7:0]        ram_rdata;
	logic [7:0]        ram_byte;
	logic [7:0]        io_byte;
	logic [7:0]        result;
	riot_op_t          op;

	logic [7:0]        port_a;
	logic [7:0]        port_a_dir;
	logic [7:0]        port_b;
	logic [7:0]        timer_value;
	logic [7:0]        timer_flag;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign s1_fire   = s1_valid_q && out_free;
	assign req.ready = !s1_valid_q || out_free;
	assign accept    = req.valid && req.ready;

	assign ram_waddr = item_s1.address[RAM_AW-1:0];
	assign ram_wr    = s1_fire && item_s1.cmd == CMD_WRITE && !item_s1.address[IO_BIT];

	assign op.fire = s1_fire;
	assign op.item = item_s1;

	riot_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr),
		.waddr (ram_waddr),
		.wdata (item_s1.write_data),
		.re    (accept),
		.raddr (req.item.address[RAM_AW-1:0]),
		.rdata (ram_rdata)
	);

	riot_ports u_ports (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.left_present  (left_present_q),
		.right_present (right_present_q),
		.port_a        (port_a),
		.port_a_dir    (port_a_dir),
		.port_b        (port_b)
	);

	riot_timer u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.timer_value (timer_value),
		.timer_flag  (timer_flag)
	);

	// Forwarded write wins over the RAM read data
	assign ram_byte = fwd_s1 ? fwd_data_s1 : ram_rdata;

	always_comb begin
		case (riot_reg_e'(item_s1.address[2:0]))
			REG_PORTA:     io_byte = port_a;
			REG_DDRA:      io_byte = port_a_dir;
			REG_PORTB:     io_byte = port_b;
			REG_DDRB:      io_byte = 8'h00;
			REG_TIMER:     io_byte = timer_value;
			REG_TIMER_ALT: io_byte = timer_value;
			REG_FLAG:      io_byte = timer_flag;
			REG_FLAG_ALT:  io_byte = timer_flag;
			default:       io_byte = 8'h00;
		endcase
		if (item_s1.cmd == CMD_READ) begin
			result = item_s1.address[IO_BIT] ? io_byte : ram_byte;
		end else begin
			result = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_present_q  <= 1'b1;
			right_present_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_LEFT_PRESENT) begin
				left_present_q <= cfg_data;
			end
			if (cfg_index == CFG_RIGHT_PRESENT) begin
				right_present_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= req.item;
			// catch a RAM write that commits in the same cycle as this read
			fwd_s1      <= ram_wr && ram_waddr == req.item.address[RAM_AW-1:0];
			fwd_data_s1 <= item_s1.write_data;
		end
		if (s1_fire) begin
			rsp_data_q <= result;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.item.read_data = rsp_data_q;

	a_fire_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> rsp_valid_q)
		else $error("work stage fired but output register is empty");

	a_accept_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_valid_q) |-> s1_fire)
		else $error("item accepted over an occupied work stage");

	a_non_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && item_s1.cmd != CMD_READ) |=> rsp.item.read_data == 8'h00)
		else $error("write or tick returned a non-zero byte");

	a_output_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> (rsp_valid_q && $stable(rsp_data_q)))
		else $error("stalled response changed");

endmodule
`default_nettype wire

>>> hdl/riot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riot_ram
// Generic single write port, single read port RAM with registered read.
// Contents start at zero at power-up and are not touched by reset.
// ----------------------------------------------------------------------------
module riot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH] = '{default: '0};

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/riot_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riot_timer
// Interval timer: prescaled countdown, expiry flag and read side effects.
// ----------------------------------------------------------------------------
module riot_timer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire riot_pkg::riot_op_t op,
	output logic [7:0]             timer_value,
	output logic [7:0]             timer_flag
);
	import riot_pkg::*;

	logic signed [TIMER_W-1:0] remain_q;
	logic [3:0]                shift_q;
	logic                      irq_en_q;
	logic                      expired_q;

	logic                      io_sel;
	logic                      is_read;
	logic                      is_write;
	logic                      is_tick;
	logic                      value_rd;
	logic                      load_wr;
	logic [3:0]                load_shift;
	logic [TIMER_W-1:0]        shifted;

	assign io_sel   = op.item.address[IO_BIT];
	assign is_read  = op.item.cmd == CMD_READ;
	assign is_write = op.item.cmd == CMD_WRITE;
	assign is_tick  = op.item.cmd == CMD_TICK;

	// Timer value at REG_TIMER and REG_TIMER_ALT: bit 2 set, bit 0 clear
	assign value_rd = is_read && io_sel && op.item.address[2] && !op.item.address[0];
	assign load_wr  = is_write && io_sel && op.item.address[2] && op.item.address[4];
	assign load_shift = PRESCALE_SHIFT[op.item.address[1:0]];
	assign shifted  = TIMER_W'(unsigned'(remain_q)) >> shift_q;

	always_comb begin
		if (remain_q >= 0) begin
			timer_value = shifted[7:0];
		end else if (remain_q >= TIMER_LOW_READ) begin
			timer_value = remain_q[7:0];
		end else begin
			timer_value = 8'h00;
		end
		if (remain_q >= 0 || (irq_en_q && expired_q)) begin
			timer_flag = 8'h00;
		end else begin
			timer_flag = FLAG_SET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q  <= TIMER_RESET;
			shift_q   <= SHIFT_RESET;
			irq_en_q  <= 1'b0;
			expired_q <= 1'b0;
		end else if (op.fire) begin
			if (load_wr) begin
				irq_en_q  <= op.item.address[3];
				expired_q <= 1'b0;
				shift_q   <= load_shift;
				remain_q  <= signed'({{(TIMER_W-8){1'b0}}, op.item.write_data} << load_shift);
			end else if (value_rd) begin
				// a read past expiry marks it seen, except exactly at minus one
				expired_q <= (remain_q < 0) && (remain_q != TIMER_MINUS_ONE);
			end else if (is_tick && remain_q > TIMER_FLOOR) begin
				remain_q <= remain_q - 20'sd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/riot_ports.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riot_ports
// Port A (sticks through direction mask and latch) and port B (switches).
// ----------------------------------------------------------------------------
module riot_ports (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire riot_pkg::riot_op_t op,
	input  wire logic               left_present,
	input  wire logic               right_present,
	output logic [7:0]              port_a,
	output logic [7:0]              port_a_dir,
	output logic [7:0]              port_b
);
	import riot_pkg::*;

	logic [7:0] dir_q;
	logic [7:0] latch_q;
	logic [7:0] pins;
	logic       pa_wr;

	// Sticks are active low; an empty jack reads zero
	assign pins[7:4] = left_present  ? ~op.item.left_stick  : 4'h0;
	assign pins[3:0] = right_present ? ~op.item.right_stick : 4'h0;

	assign port_a     = (pins & ~dir_q) | (latch_q & dir_q);
	assign port_a_dir = dir_q;
	assign port_b     = PORTB_COLOUR
		| {op.item.right_difficulty, op.item.left_difficulty, 4'b0000,
		   !op.item.select_switch, !op.item.reset_switch};

	assign pa_wr = op.fire && op.item.cmd == CMD_WRITE
		&& op.item.address[IO_BIT] && !op.item.address[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= 8'h00;
			latch_q <= 8'h00;
		end else if (pa_wr) begin
			case (op.item.address[1:0])
				PA_SEL_LATCH: begin
					latch_q <= (op.item.write_data & dir_q) | (latch_q & ~dir_q);
				end
				PA_SEL_DDR: begin
					dir_q <= op.item.write_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> bench/tb_ram_io_timer_6532.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ram_io_timer_6532
// Self-checking bench for the RAM, I/O and timer block. A short table of
// directed bus items runs first. Random sequences then follow under four
// joystick jack settings: timer loads with countdowns, port A set-ups and
// RAM write/read-back. Each response byte is checked in order: typed rows
// against the table, others against a behavioural RAM, port and timer model.
// ----------------------------------------------------------------------------
module tb_ram_io_timer_6532;
	timeunit 1ns;
	timeprecision 1ps;
	import riot_pkg::*;

	localparam int TOTAL_ITEMS     = 500;
	localparam int CYCLE_LIMIT     = 400_000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_OFF_AFTER  = 250;
	localparam int HOLD_OFF_CYCLES = 200;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam logic [1:0] PRE_DIV1    = 2'd0;
	localparam logic [1:0] PRE_DIV1024 = 2'd3;

	// Address bits of an I/O write
	localparam int TMR_SEL_BIT  = 2;
	localparam int TMR_IRQ_BIT  = 3;
	localparam int TMR_LOAD_BIT = 4;

	typedef struct {
		riot_req_t  item;
		bit         typed;
		logic [7:0] want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic cfg_data;

	riot_req_if req_ch();
	riot_rsp_if rsp_ch();

	ram_io_timer_6532 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5ns clk = ~clk;

	// Model state
	logic [7:0]                shadow_ram [RAM_DEPTH];
	logic [7:0]                ddra_now;
	logic [7:0]                latch_now;
	logic signed [TIMER_W-1:0] count_left;
	logic [3:0]                scale_shift;
	logic                      irq_armed;
	logic                      underflow_seen;
	logic                      left_jack;
	logic                      right_jack;

	logic [7:0] read_data_due [$];
	int         fail_count   = 0;
	int         results_seen = 0;
	int         items_sent   = 0;
	int         cycle_count  = 0;
	bit         sender_calm  = 1'b0;

	function automatic logic [7:0] predict_read_data(input riot_req_t it);
		logic [7:0] sticks;
		logic [7:0] rd;
		rd = 8'h00;
		case (it.cmd)
		CMD_READ: begin
			if (!it.address[IO_BIT]) begin
				rd = shadow_ram[it.address[RAM_AW-1:0]];
			end else begin
				case (riot_reg_e'(it.address[2:0]))
				REG_PORTA: begin
					// pressed reads low; an empty jack reads low on every bit
					sticks = {left_jack ? ~it.left_stick : 4'h0,
						right_jack ? ~it.right_stick : 4'h0};
					rd = (sticks & ~ddra_now) | (latch_now & ddra_now);
				end
				REG_DDRA: rd = ddra_now;
				REG_PORTB: rd = PORTB_COLOUR | {it.right_difficulty, it.left_difficulty,
					4'h0, ~it.select_switch, ~it.reset_switch};
				REG_TIMER, REG_TIMER_ALT: begin
					if (count_left >= 0) begin
						rd = 8'(count_left >> scale_shift);
						underflow_seen = 1'b0;
					end else begin
						rd = (count_left >= TIMER_LOW_READ) ? count_left[7:0] : 8'h00;
						underflow_seen = (count_left != TIMER_MINUS_ONE);
					end
				end
				REG_FLAG, REG_FLAG_ALT:
					rd = (count_left >= 0 || (irq_armed && underflow_seen)) ? 8'h00 : FLAG_SET;
				default: rd = 8'h00;
				endcase
			end
		end
		CMD_WRITE: begin
			if (!it.address[IO_BIT]) begin
				shadow_ram[it.address[RAM_AW-1:0]] = it.write_data;
			end else if (it.address[TMR_SEL_BIT]) begin
				if (it.address[TMR_LOAD_BIT]) begin
					irq_armed = it.address[TMR_IRQ_BIT];
					underflow_seen = 1'b0;
					scale_shift = PRESCALE_SHIFT[it.address[1:0]];
					count_left = {{(TIMER_W-8){1'b0}}, it.write_data} << scale_shift;
				end
			end else if (it.address[1:0] == PA_SEL_LATCH) begin
				latch_now = (it.write_data & ddra_now) | (latch_now & ~ddra_now);
			end else if (it.address[1:0] == PA_SEL_DDR) begin
				ddra_now = it.write_data;
			end
		end
		CMD_TICK: begin
			if (count_left > TIMER_FLOOR) count_left = count_left - 20'sd1;
		end
		default: rd = 8'h00;
		endcase
		return rd;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [ADDR_W-1:0] reg_at(input logic [5:0] upper,
		input logic [2:0] sel);
		return {1'b1, upper, sel};
	endfunction

	function automatic logic [ADDR_W-1:0] timer_load(input logic [3:0] upper,
		input logic irq, input logic [1:0] pre);
		return {1'b1, upper, 1'b1, irq, 1'b1, pre};
	endfunction

	function automatic riot_req_t any_levels(input logic [1:0] cmd,
		input logic [ADDR_W-1:0] addr, input logic [7:0] data);
		riot_req_t it;
		it.cmd              = cmd;
		it.address          = addr;
		it.write_data       = data;
		it.left_stick       = 4'($urandom);
		it.right_stick      = 4'($urandom);
		it.reset_switch     = 1'($urandom);
		it.select_switch    = 1'($urandom);
		it.left_difficulty  = 1'($urandom);
		it.right_difficulty = 1'($urandom);
		return it;
	endfunction

	// sw holds reset, select, left difficulty, right difficulty
	function automatic script_row_t step_row(input logic [1:0] cmd,
		input logic [ADDR_W-1:0] addr, input logic [7:0] data, input logic [3:0] ls,
		input logic [3:0] rs, input logic [3:0] sw, input bit typed, input logic [7:0] want);
		script_row_t r;
		r.item = '{cmd: cmd, address: addr, write_data: data, left_stick: ls,
			right_stick: rs, reset_switch: sw[3], select_switch: sw[2],
			left_difficulty: sw[1], right_difficulty: sw[0]};
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	task automatic offer(input riot_req_t it, input bit typed, input logic [7:0] want);
		logic [7:0] guess;
		int         gap;
		req_ch.valid <= 1'b1;
		req_ch.item  <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		guess = predict_read_data(it);
		read_data_due.push_back(typed ? want : guess);
		if (it.cmd != CMD_UNUSED) items_sent++;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (read_data_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_jacks(input logic left, input logic right);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LEFT_PRESENT;
		cfg_data  <= left;
		@(posedge clk);
		cfg_index <= CFG_RIGHT_PRESENT;
		cfg_data  <= right;
		@(posedge clk);
		cfg_we     <= 1'b0;
		left_jack  = left;
		right_jack = right;
	endtask

	task automatic random_sequence(input bit saturate);
		logic [ADDR_W-1:0] addrs [$];
		logic [ADDR_W-1:0] a;
		logic [7:0]        data;
		logic [1:0]        pre;
		bit                long_run;
		int                kind;
		int                n;
		sender_calm = ($urandom_range(0, 2) == 0);
		kind = saturate ? 0 : $urandom_range(0, 9);
		case (kind)
		0, 1, 2: begin
			// load, count down, sample value and flag on the way in short runs and at the end
			long_run = saturate || ($urandom_range(0, 39) == 0);
			if (long_run) begin
				pre  = PRE_DIV1;
				data = 8'($urandom_range(0, 3));
				n    = $urandom_range(262, 300);
			end else begin
				pre  = 2'($urandom);
				data = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
				n    = $urandom_range(1, 12);
			end
			offer(any_levels(CMD_WRITE, timer_load(4'($urandom), 1'($urandom), pre), data),
				1'b0, 8'h00);
			repeat (n) begin
				if (!long_run && $urandom_range(0, 3) == 0)
					offer(any_levels(CMD_READ, reg_at(6'($urandom),
						3'($urandom_range(REG_TIMER, REG_FLAG_ALT))), 8'($urandom)),
						1'b0, 8'h00);
				else
					offer(any_levels(CMD_TICK, 10'($urandom), 8'($urandom)), 1'b0, 8'h00);
			end
			repeat ($urandom_range(1, 3))
				offer(any_levels(CMD_READ, reg_at(6'($urandom),
					3'($urandom_range(REG_TIMER, REG_FLAG_ALT))), 8'($urandom)),
					1'b0, 8'h00);
		end
		3, 4: begin
			offer(any_levels(CMD_WRITE, reg_at(6'($urandom), {1'b0, PA_SEL_DDR}),
				8'($urandom)), 1'b0, 8'h00);
			offer(any_levels(CMD_WRITE, reg_at(6'($urandom), {1'b0, PA_SEL_LATCH}),
				8'($urandom)), 1'b0, 8'h00);
			repeat ($urandom_range(1, 3))
				offer(any_levels(CMD_READ, reg_at(6'($urandom),
					($urandom_range(0, 3) == 0) ? REG_DDRA : REG_PORTA), 8'($urandom)),
					1'b0, 8'h00);
		end
		5, 6: begin
			// write a few bytes, read them back through aliased addresses
			repeat ($urandom_range(1, 4)) begin
				a = {1'b0, 9'($urandom)};
				addrs.push_back(a);
				offer(any_levels(CMD_WRITE, a, 8'($urandom)), 1'b0, 8'h00);
			end
			foreach (addrs[k])
				offer(any_levels(CMD_READ, {1'b0, 2'($urandom), addrs[k][RAM_AW-1:0]},
					8'($urandom)), 1'b0, 8'h00);
			offer(any_levels(CMD_READ, {1'b0, 9'($urandom)}, 8'($urandom)), 1'b0, 8'h00);
		end
		7: begin
			repeat ($urandom_range(1, 4))
				offer(any_levels(2'($urandom), 10'($urandom), 8'($urandom)), 1'b0, 8'h00);
		end
		8: begin
			repeat ($urandom_range(1, 20))
				offer(any_levels(CMD_TICK, 10'($urandom), 8'($urandom)), 1'b0, 8'h00);
		end
		default: begin
			repeat ($urandom_range(1, 4))
				offer(any_levels(CMD_READ, reg_at(6'($urandom), 3'($urandom)),
					8'($urandom)), 1'b0, 8'h00);
		end
		endcase
	endtask

	initial begin : stimulus
		logic [1:0]  jack_plan [4];
		int          phase_end;
		script_row_t script [$];
		req_ch.valid = 1'b0;
		req_ch.item  = '0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_LEFT_PRESENT;
		cfg_data     = 1'b0;
		arst_n       = 1'b0;
		foreach (shadow_ram[k]) shadow_ram[k] = 8'h00;
		ddra_now       = 8'h00;
		latch_now      = 8'h00;
		count_left     = TIMER_RESET;
		scale_shift    = SHIFT_RESET;
		irq_armed      = 1'b0;
		underflow_seen = 1'b0;
		left_jack      = 1'b1;
		right_jack     = 1'b1;
		jack_plan = '{2'b00, 2'b10, 2'b01, 2'b11};
		script = '{
			step_row(CMD_READ, reg_at(6'h00, REG_TIMER), 8'h00, 4'hF, 4'hF, 4'h0, 1, 8'hFF),
			step_row(CMD_READ, reg_at(6'h00, REG_FLAG), 8'h00, 4'hF, 4'hF, 4'h0, 1, 8'h00),
			step_row(CMD_READ, reg_at(6'h00, REG_PORTB), 8'h00, 4'h0, 4'h0, 4'hA, 1, 8'h4A),
			step_row(CMD_READ, reg_at(6'h3F, REG_PORTB), 8'hFF, 4'h0, 4'h0, 4'h5, 1, 8'h89),
			step_row(CMD_READ, reg_at(6'h00, REG_PORTA), 8'h00, 4'hF, 4'h0, 4'h0, 1, 8'h0F),
			step_row(CMD_READ, reg_at(6'h3F, REG_PORTA), 8'h00, 4'h0, 4'hF, 4'hF, 1, 8'hF0),
			step_row(CMD_READ, reg_at(6'h00, REG_DDRA), 8'h00, 4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_READ, reg_at(6'h3F, REG_DDRB), 8'h00, 4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_WRITE, 10'h000, 8'hFF, 4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_WRITE, 10'h1FF, 8'h5A, 4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_READ, 10'h080, 8'h00, 4'h0, 4'h0, 4'h0, 0, 8'h00),
			step_row(CMD_READ, 10'h17F, 8'h00, 4'h0, 4'h0, 4'h0, 0, 8'h00),
			step_row(CMD_READ, 10'h055, 8'h00, 4'h0, 4'h0, 4'h0, 0, 8'h00),
			step_row(CMD_WRITE, reg_at(6'h00, {1'b0, PA_SEL_DDR}), 8'hF0,
				4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_WRITE, reg_at(6'h00, {1'b0, PA_SEL_LATCH}), 8'hFF,
				4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_WRITE, reg_at(6'h00, REG_PORTB), 8'hFF, 4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_READ, reg_at(6'h00, REG_PORTA), 8'h00, 4'h5, 4'hA, 4'h0, 0, 8'h00),
			step_row(CMD_WRITE, {1'b1, 4'h0, 1'b0, 1'b1, 1'b1, PRE_DIV1024}, 8'h77,
				4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_WRITE, timer_load(4'h0, 1'b1, PRE_DIV1), 8'h02,
				4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_TICK, 10'h000, 8'h00, 4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_TICK, 10'h3FF, 8'hFF, 4'hF, 4'hF, 4'hF, 1, 8'h00),
			step_row(CMD_TICK, 10'h000, 8'h00, 4'h0, 4'h0, 4'h0, 1, 8'h00),
			step_row(CMD_READ, reg_at(6'h00, REG_FLAG_ALT), 8'h00, 4'h0, 4'h0, 4'h0, 0, 8'h00),
			step_row(CMD_READ, reg_at(6'h00, REG_TIMER_ALT), 8'h00, 4'h0, 4'h0, 4'h0, 0, 8'h00),
			step_row(CMD_UNUSED, 10'h3FF, 8'hFF, 4'hF, 4'hF, 4'hF, 1, 8'h00)
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		foreach (script[i]) offer(script[i].item, script[i].typed, script[i].want);
		// each jack setting starts from a drained block; split what is left evenly
		foreach (jack_plan[p]) begin
			settle();
			program_jacks(jack_plan[p][1], jack_plan[p][0]);
			phase_end = items_sent + (TOTAL_ITEMS - items_sent) / (4 - p);
			random_sequence(p == 0);
			while (items_sent < phase_end) random_sequence(1'b0);
		end
		settle();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : drive_ready
		int run;
		int gap;
		bit held;
		held = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			// hold off once, long enough to back the block up into its input
			if (!held && results_seen >= HOLD_OFF_AFTER) begin
				held = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk) rsp_ch.ready <= 1'b0;
			end
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			repeat (run) @(posedge clk) rsp_ch.ready <= 1'b1;
			gap = pick_gap();
			repeat (gap) @(posedge clk) rsp_ch.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_read_data
		logic [7:0] want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (read_data_due.size() == 0) begin
				$error("read_data: no item expected, got %02h", rsp_ch.item.read_data);
				fail_count++;
			end else begin
				want = read_data_due.pop_front();
				if (rsp_ch.item.read_data !== want) begin
					$error("read_data: expected %02h, got %02h", want, rsp_ch.item.read_data);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
`default_nettype wire
